// File: hw/rtl/setr_pkg.sv
// Package for the scan elevation table tracker: opcodes, status codes,
// controller command/status structs. No dependencies.
package setr_pkg;

  localparam logic [1:0] OP_HEADER  = 2'd0;
  localparam logic [1:0] OP_CUT     = 2'd1;
  localparam logic [1:0] OP_NEAREST = 2'd2;
  localparam logic [1:0] OP_ANGLE   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  localparam logic [1:0] DC_SAME    = 2'd0;
  localparam logic [1:0] DC_PATTERN = 2'd1;
  localparam logic [1:0] DC_COUNT   = 2'd2;
  localparam logic [1:0] DC_ANGLES  = 2'd3;

  localparam logic [7:0]  MODE_UNKNOWN = 8'd0;
  localparam logic signed [15:0] BAD_ANGLE = -16'sd10000;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic exec;      // header / cut / query setup step
    logic scan_rd;   // issue read of scan entry
    logic scan_cmp;  // compare returned entry
    logic finish;    // build result register
  } setr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cut_wr;    // cut item needs a compare read (write happens with it)
    logic scan_go;   // another entry remains to read
  } setr_sts_t;

endpackage

// File: hw/rtl/setr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module setr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: hw/rtl/setr_ctrl.sv
// Controller state machine for the tracker.
// Depends on setr_pkg.
module setr_ctrl import setr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  logic      item_is_scan,
  input  setr_sts_t sts,
  output setr_cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_CMP  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // read issued here; registered data is there in the next cycle
        cmd.exec = 1'b1;
        if (item_is_scan || sts.cut_wr) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.scan_go) begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshake never offered to both sides at once
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("ready and result valid together");
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_OUT && !out_tready) |=> state_r == S_OUT)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
      (in_tvalid && in_tready) |=> state_r == S_EXEC)
    else $error("accepted item not executed");
endmodule

// File: hw/rtl/setr_dp.sv
// Datapath: volume registers, angle banks in RAM, cut handling and scan unit.
// Depends on setr_pkg and setr_ram.
module setr_dp import setr_pkg::*; #(
  parameter int MAX_ELEVATIONS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  setr_cmd_t         cmd,
  output setr_sts_t         sts,
  output logic              item_is_scan,
  input  logic [1:0]        op,
  input  logic [31:0]       vol_seq,
  input  logic              initial_volume,
  input  logic [7:0]        weather_mode,
  input  logic signed [15:0] pattern_number,
  input  logic [7:0]        cut_count,
  input  logic [7:0]        cut_elevation_index,
  input  logic signed [15:0] angle,
  input  logic [7:0]        query_index,
  output logic [1:0]        status,
  output logic [1:0]        difference_code,
  output logic [5:0]        nearest_index,
  output logic signed [15:0] angle_out,
  output logic [7:0]        mode_now,
  output logic [7:0]        mode_before,
  output logic signed [15:0] pattern_now,
  output logic signed [15:0] pattern_before,
  output logic              initial_flag,
  output logic [31:0]       initial_number,
  output logic [31:0]       current_number,
  output logic [5:0]        elevation_count
);
  localparam int IW = $clog2(MAX_ELEVATIONS) > 0 ? $clog2(MAX_ELEVATIONS) : 1;
  localparam int CW = $clog2(MAX_ELEVATIONS + 1);
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_ELEVATIONS);

  // captured item
  logic [1:0]  op_r;
  logic [31:0] vnum_r;
  logic        init_r;
  logic [7:0]  mode_in_r, ncut_r, cidx_r, qidx_r;
  logic signed [15:0] pat_in_r, ang_r;

  // volume state
  logic        bank_r;
  logic [CW-1:0] cnt_now_r, cnt_bef_r;
  logic [31:0] vol_now_r, vol_init_r;
  logic        init_bit_r;
  logic [7:0]  mode0_r, mode1_r;
  logic signed [15:0] pat0_r, pat1_r;
  logic [7:0]  cuts_rem_r;
  logic [8:0]  last_idx_r;
  logic        diff_r, disc_r;

  // per-item work
  logic [1:0]  st_r;
  logic        cmp_cut_r;           // compare pending for a stored cut
  logic [CW-1:0] scan_i_r;          // next index to read
  logic [CW-1:0] cmp_i_r;           // index of data arriving
  logic [5:0]  near_r;
  logic [16:0] best_r;
  logic signed [15:0] aout_r;

  // RAM
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [15:0] rd_data;

  // one bank per half of the address space
  setr_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(ang_r),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // cut decision in EXEC
  logic cut_live, cut_store, q_ok;
  assign cut_live  = (op_r == OP_CUT) && (cuts_rem_r != 8'd0) && !disc_r;
  assign cut_store = cut_live && ({1'b0, cidx_r} != last_idx_r) && (cnt_now_r < MAXC);
  assign q_ok = (qidx_r != 8'd0) && ({1'b0, qidx_r} <= 9'(cnt_now_r));

  assign item_is_scan = (op_r == OP_NEAREST) || (op_r == OP_ANGLE);
  assign sts.cut_wr   = cut_store && (cnt_now_r < cnt_bef_r);
  assign sts.scan_go  = (op_r == OP_NEAREST) && (scan_i_r < cnt_now_r);

  assign wr_en   = cmd.exec && cut_store;
  assign wr_addr = {bank_r, cnt_now_r[IW-1:0]};

  // read address: old bank for a cut compare, query entry, or scan entry
  always_comb begin
    if (cmd.exec && op_r == OP_CUT) begin
      rd_addr = {~bank_r, cnt_now_r[IW-1:0]};
    end else if (cmd.exec && op_r == OP_ANGLE) begin
      rd_addr = {bank_r, IW'(qidx_r - 8'd1)};
    end else if (cmd.exec) begin
      rd_addr = {bank_r, IW'(0)};
    end else begin
      rd_addr = {bank_r, scan_i_r[IW-1:0]};
    end
  end

  // absolute difference against the lookup angle
  logic signed [16:0] dsub;
  logic [16:0] dabs;
  assign dsub = 17'(ang_r) - 17'(rd_data);
  assign dabs = dsub[16] ? 17'(-dsub) : 17'(dsub);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op; vnum_r <= vol_seq; init_r <= initial_volume;
      mode_in_r <= weather_mode; pat_in_r <= pattern_number; ncut_r <= cut_count;
      cidx_r <= cut_elevation_index; ang_r <= angle; qidx_r <= query_index;
    end
    if (cmd.exec) begin
      // status for cuts/headers
      if (op_r == OP_HEADER && vnum_r == vol_now_r && vol_now_r != vol_init_r) begin
        st_r <= ST_DUPLICATE;
      end else if (op_r == OP_CUT && (!cut_live || {1'b0, cidx_r} == last_idx_r)) begin
        st_r <= ST_IGNORED;
      end else if (op_r == OP_CUT && cnt_now_r >= MAXC) begin
        st_r <= ST_OVERFLOW;
      end else begin
        st_r <= ST_OK;
      end
      near_r <= 6'd0;
      best_r <= '0;
      scan_i_r <= CW'(1);
      cmp_i_r <= '0;
      cmp_cut_r <= (op_r == OP_CUT);
      aout_r <= (op_r == OP_ANGLE && !q_ok) ? BAD_ANGLE : 16'sd0;
    end
    if (cmd.scan_cmp) begin
      if (cmp_cut_r) begin
        cmp_cut_r <= 1'b0;
      end else if (op_r == OP_ANGLE) begin
        if (q_ok) aout_r <= rd_data;
      end else if (cmp_i_r < cnt_now_r) begin
        if (near_r == 6'd0 || dabs < best_r) begin
          best_r <= dabs;
          near_r <= 6'(cmp_i_r) + 6'd1;
        end
      end
      cmp_i_r <= scan_i_r;
      if (cmd.scan_rd) scan_i_r <= scan_i_r + CW'(1);
    end
  end

  // volume state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0; cnt_now_r <= '0; cnt_bef_r <= '0;
      vol_now_r <= '0; vol_init_r <= '0; init_bit_r <= 1'b1;
      mode0_r <= MODE_UNKNOWN; mode1_r <= MODE_UNKNOWN;
      pat0_r <= '0; pat1_r <= '0; cuts_rem_r <= '0;
      last_idx_r <= 9'h1FF; diff_r <= 1'b0; disc_r <= 1'b0;
    end else begin
      if (cmd.exec && op_r == OP_HEADER) begin
        cuts_rem_r <= ncut_r;
        if (vnum_r == vol_now_r && vol_now_r != vol_init_r) begin
          disc_r <= 1'b1;
        end else begin
          vol_now_r <= vnum_r; init_bit_r <= init_r;
          if (init_r) vol_init_r <= vnum_r;
          mode1_r <= mode0_r; mode0_r <= mode_in_r;
          pat1_r <= pat0_r; pat0_r <= pat_in_r;
          bank_r <= ~bank_r; cnt_bef_r <= cnt_now_r; cnt_now_r <= '0;
          last_idx_r <= 9'h1FF; diff_r <= 1'b0; disc_r <= 1'b0;
        end
      end
      if (cmd.exec && cut_live) begin
        cuts_rem_r <= cuts_rem_r - 8'd1;
        if ({1'b0, cidx_r} != last_idx_r) begin
          if (cnt_now_r >= MAXC) begin
            disc_r <= 1'b1;
          end else begin
            last_idx_r <= {1'b0, cidx_r};
            cnt_now_r <= cnt_now_r + CW'(1);
          end
        end
      end
      // old-bank angle returned for a stored cut
      if (cmd.scan_cmp && cmp_cut_r && rd_data != ang_r) diff_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= st_r;
      if (pat0_r != pat1_r) difference_code <= DC_PATTERN;
      else if (cnt_now_r != cnt_bef_r) difference_code <= DC_COUNT;
      else if (diff_r) difference_code <= DC_ANGLES;
      else difference_code <= DC_SAME;
      nearest_index <= near_r;
      angle_out <= aout_r;
      mode_now <= mode0_r; mode_before <= mode1_r;
      pattern_now <= pat0_r; pattern_before <= pat1_r;
      initial_flag <= init_bit_r; initial_number <= vol_init_r;
      current_number <= vol_now_r;
      elevation_count <= 6'(cnt_now_r);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_now_r <= MAXC)
    else $error("count beyond table");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_bef_r <= MAXC)
    else $error("previous count beyond table");
  assert property (@(posedge clk) disable iff (!rst_n)
      wr_en |-> op_r == OP_CUT && !disc_r)
    else $error("bank written outside a live cut");
endmodule

// File: hw/rtl/scan_elevation_table_tracker_core.sv
// Top level of the scan elevation table tracker.
// Depends on setr_pkg, setr_ctrl, setr_dp, setr_ram.
// Headers and cuts with no compare go from EXEC straight to FIN; angle queries and
// cuts compared against the previous table pass through CMP, and nearest lookups
// stay in CMP, one stored angle compared per cycle through the RAM read port.
// One item at a time: a new item is taken only once the result has been accepted.
// Synchronous active-low reset clears all control and volume state; the
// angle banks need no clearing.
module scan_elevation_table_tracker_core import setr_pkg::*; #(
  parameter int MAX_ELEVATIONS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[1:0], vol_seq[33:2], initial_volume[34], weather_mode[42:35],
  // pattern_number[58:43], cut_count[66:59], cut_elevation_index[74:67],
  // angle[90:75], query_index[98:91], zero fill to 104
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], difference_code[3:2], nearest_index[9:4], angle_out[25:10],
  // mode_now[33:26], mode_before[41:34], pattern_now[57:42],
  // pattern_before[73:58], initial_flag[74], initial_number[106:75],
  // current_number[138:107], elevation_count[144:139], zero fill to 152
  output logic [151:0] out_tdata
);
  setr_cmd_t cmd;
  setr_sts_t sts;
  logic      is_scan;
  logic [1:0] status, dcode;
  logic [5:0] near, ecnt;
  logic signed [15:0] aout, pnow, pbef;
  logic [7:0] mnow, mbef;
  logic iflag;
  logic [31:0] inum, cnum;

  setr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .item_is_scan(is_scan), .sts(sts), .cmd(cmd)
  );

  setr_dp #(.MAX_ELEVATIONS(MAX_ELEVATIONS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .item_is_scan(is_scan),
    .op(in_tdata[1:0]), .vol_seq(in_tdata[33:2]),
    .initial_volume(in_tdata[34]), .weather_mode(in_tdata[42:35]),
    .pattern_number(in_tdata[58:43]), .cut_count(in_tdata[66:59]),
    .cut_elevation_index(in_tdata[74:67]), .angle(in_tdata[90:75]),
    .query_index(in_tdata[98:91]),
    .status(status), .difference_code(dcode), .nearest_index(near),
    .angle_out(aout), .mode_now(mnow), .mode_before(mbef),
    .pattern_now(pnow), .pattern_before(pbef), .initial_flag(iflag),
    .initial_number(inum), .current_number(cnum), .elevation_count(ecnt)
  );

  assign out_tdata = {7'd0, ecnt, cnum, inum, iflag, pbef, pnow, mbef, mnow,
                      aout, near, dcode, status};
endmodule

// File: test/tb_scan_elevation_table_tracker_core.sv
// Testbench for scan_elevation_table_tracker_core: directed table, overflow fill,
// receiver hold-off and random volumes, every result checked against an in-bench
// model of the elevation tables. Depends on setr_pkg and the core RTL only.
module tb_scan_elevation_table_tracker_core import setr_pkg::*;;

  localparam int MAXE = 32;
  localparam int CYCLE_LIMIT = 2000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;

  scan_elevation_table_tracker_core #(.MAX_ELEVATIONS(MAXE)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [7:0]         qidx;
    logic signed [15:0] ang;
    logic [7:0]         cidx;
    logic [7:0]         ncuts;
    logic signed [15:0] pat;
    logic [7:0]         mode;
    logic               init;
    logic [31:0]        vnum;
    logic [1:0]         op;
  } item_t;

  typedef struct packed {
    logic [5:0]         elev_count;
    logic [31:0]        cur_num;
    logic [31:0]        init_num;
    logic               init_flag;
    logic signed [15:0] pat_before;
    logic signed [15:0] pat_now;
    logic [7:0]         mode_before;
    logic [7:0]         mode_now;
    logic signed [15:0] angle_out;
    logic [5:0]         nearest;
    logic [1:0]         diff;
    logic [1:0]         status;
  } table_result_t;

  // Tracker state mirror
  logic signed [15:0] banks [0:2*MAXE-1];
  logic        sel;
  int unsigned cnt_now, cnt_before, cuts_left;
  logic [31:0] vol_now, vol_init;
  logic        init_bit, differ, dropping;
  logic [7:0]  mode_cur, mode_prev;
  logic signed [15:0] pat_cur, pat_prev;
  int          last_idx;

  table_result_t expected_results[$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_off = 0;

  function automatic void tracker_reset();
    sel = 0; cnt_now = 0; cnt_before = 0; cuts_left = 0;
    vol_now = 0; vol_init = 0; init_bit = 1; differ = 0; dropping = 0;
    mode_cur = MODE_UNKNOWN; mode_prev = MODE_UNKNOWN;
    pat_cur = 0; pat_prev = 0; last_idx = -1;
  endfunction

  function automatic table_result_t track_item(item_t it);
    table_result_t r;
    int best, d;
    r = '0;
    case (it.op)
      OP_HEADER: begin
        cuts_left = it.ncuts;
        if (it.vnum == vol_now && vol_now != vol_init) begin
          r.status = ST_DUPLICATE; dropping = 1;
        end else begin
          vol_now = it.vnum; init_bit = it.init;
          if (it.init) vol_init = it.vnum;
          mode_prev = mode_cur; mode_cur = it.mode;
          pat_prev = pat_cur; pat_cur = it.pat;
          sel = ~sel; cnt_before = cnt_now; cnt_now = 0;
          last_idx = -1; differ = 0; dropping = 0;
        end
      end
      OP_CUT: begin
        if (cuts_left == 0 || dropping) r.status = ST_IGNORED;
        else begin
          cuts_left--;
          if (int'(it.cidx) == last_idx) r.status = ST_IGNORED;
          else if (cnt_now >= MAXE) begin
            r.status = ST_OVERFLOW; dropping = 1;
          end else begin
            banks[sel*MAXE + cnt_now] = it.ang;
            if (cnt_now < cnt_before && banks[(sel ? 0 : MAXE) + cnt_now] != it.ang)
              differ = 1;
            last_idx = it.cidx;
            cnt_now++;
          end
        end
      end
      OP_NEAREST: begin
        best = 0;
        for (int i = 0; i < cnt_now; i++) begin
          d = int'(it.ang) - int'(banks[sel*MAXE + i]);
          if (d < 0) d = -d;
          if (r.nearest == 0 || d < best) begin
            best = d; r.nearest = 6'(i + 1);
          end
        end
      end
      default: begin
        if (it.qidx > 0 && it.qidx <= cnt_now) r.angle_out = banks[sel*MAXE + it.qidx - 1];
        else r.angle_out = BAD_ANGLE;
      end
    endcase
    if (pat_cur != pat_prev) r.diff = DC_PATTERN;
    else if (cnt_now != cnt_before) r.diff = DC_COUNT;
    else if (differ) r.diff = DC_ANGLES;
    else r.diff = DC_SAME;
    r.mode_now = mode_cur; r.mode_before = mode_prev;
    r.pat_now = pat_cur; r.pat_before = pat_prev;
    r.init_flag = init_bit; r.init_num = vol_init; r.cur_num = vol_now;
    r.elev_count = 6'(cnt_now);
    return r;
  endfunction

  function automatic item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[98:0];
  endfunction

  // Offer one transaction, with random idling before it unless bursting;
  // valid stays up after acceptance until the next idle cycle or drain
  task automatic send(item_t it, bit burst);
    if (!burst) begin
      while ($urandom_range(99) < 35) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tdata <= {5'b0, it};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(track_item(it));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, always ready in a mid-run window, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else if (cycles > 40000 && cycles < 60000) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 35);
  end

  // Result check
  always @(posedge clk) begin
    table_result_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[144:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp = expected_results.pop_front();
        if (got.status != exp.status)
          $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        if (got.diff != exp.diff)
          $display("%0t: difference exp %0d got %0d", $time, exp.diff, got.diff);
        if (got.nearest != exp.nearest)
          $display("%0t: nearest exp %0d got %0d", $time, exp.nearest, got.nearest);
        if (got.angle_out != exp.angle_out)
          $display("%0t: angle exp %0d got %0d", $time, exp.angle_out, got.angle_out);
        if (got[144:26] != exp[144:26])
          $display("%0t: volume state exp %h got %h", $time, exp[144:26], got[144:26]);
        if (got != exp) errors++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Directed table: op, vnum, init, mode, pat, ncuts, cidx, ang, qidx, expected status
  typedef struct {
    logic [1:0] op; logic [31:0] vnum; logic init; logic [7:0] mode;
    logic signed [15:0] pat; logic [7:0] ncuts; logic [7:0] cidx;
    logic signed [15:0] ang; logic [7:0] qidx; int exp_status;
  } dir_row_t;

  dir_row_t directed [] = '{
    '{OP_NEAREST, 0, 0, 0, 0, 0, 0, 16'sh7fff, 0, ST_OK},           // empty table
    '{OP_ANGLE, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK},                      // out of range
    '{OP_CUT, 0, 0, 0, 0, 0, 3, 5, 0, ST_IGNORED},                   // stray cut
    '{OP_HEADER, 32'hffffffff, 1, 8'hff, 16'sh7fff, 4, 0, 0, 0, ST_OK},
    '{OP_CUT, 0, 0, 0, 0, 0, 0, 16'sh8000, 0, ST_OK},
    '{OP_CUT, 0, 0, 0, 0, 0, 0, 100, 0, ST_IGNORED},                 // repeated index
    '{OP_CUT, 0, 0, 0, 0, 0, 255, 16'sh7fff, 0, ST_OK},
    '{OP_CUT, 0, 0, 0, 0, 0, 7, 0, 0, ST_OK},
    '{OP_NEAREST, 0, 0, 0, 0, 0, 0, -1, 0, -1},                      // extreme angles
    '{OP_ANGLE, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK},
    '{OP_ANGLE, 0, 0, 0, 0, 0, 0, 0, 3, -1},
    '{OP_ANGLE, 0, 0, 0, 0, 0, 0, 0, 255, ST_OK},
    '{OP_HEADER, 7, 0, 1, 16'sh8000, 2, 0, 0, 0, ST_OK},
    '{OP_HEADER, 7, 0, 2, 5, 2, 0, 0, 0, ST_DUPLICATE},
    '{OP_CUT, 0, 0, 0, 0, 0, 1, 9, 0, ST_IGNORED},                   // discarded
    '{OP_HEADER, 8, 0, 3, 16'sh8000, 40, 0, 0, 0, ST_OK}
  };

  initial begin
    item_t it;
    tracker_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      it = '0;
      it.op = directed[k].op; it.vnum = directed[k].vnum; it.init = directed[k].init;
      it.mode = directed[k].mode; it.pat = directed[k].pat; it.ncuts = directed[k].ncuts;
      it.cidx = directed[k].cidx; it.ang = directed[k].ang; it.qidx = directed[k].qidx;
      if (directed[k].exp_status >= 0) begin
        send(it, 0);
        if (expected_results[$].status != directed[k].exp_status) begin
          $display("%0t: table row %0d status exp %0d, model %0d", $time, k,
                   directed[k].exp_status, expected_results[$].status);
          errors++;
        end
      end else send(it, 0);
    end
    // Fill past capacity to reach overflow, then drop the rest
    for (int c = 0; c < 36; c++) begin
      it = rand_item(); it.op = OP_CUT; it.cidx = 8'(c);
      send(it, 0);
    end
    drain();

    // Long receiver hold-off while items keep coming
    hold_off = 1;
    fork
      begin repeat (300) @(posedge clk); hold_off = 0; end
      for (int n = 0; n < 20; n++) begin
        it = rand_item(); it.op = OP_ANGLE; it.qidx = 8'($urandom_range(33));
        send(it, 1);
      end
    join
    drain();

    // Random volumes: header, cuts, queries; some noise
    for (int n = 0; n < 2000; ) begin
      int ncuts;
      it = rand_item();
      it.op = OP_HEADER;
      if ($urandom_range(9) == 0) it.vnum = vol_now;
      it.pat = ($urandom_range(3) == 0) ? pat_cur : it.pat;
      ncuts = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12);
      if ($urandom_range(7) == 0) ncuts = cnt_now;
      it.ncuts = 8'(ncuts);
      it.init = ($urandom_range(5) == 0);
      send(it, 0); n++;
      for (int c = 0; c < ncuts && n < 2000; c++) begin
        it = rand_item(); it.op = OP_CUT;
        if ($urandom_range(9) != 0) it.cidx = 8'(c + 1);
        if (c < cnt_before && $urandom_range(1)) it.ang = banks[(sel ? 0 : MAXE) + c];
        else it.ang = $urandom_range(1) ? it.ang : $signed(16'($urandom_range(900)));
        send(it, cycles > 40000 && cycles < 60000); n++;
      end
      repeat ($urandom_range(4)) begin
        it = rand_item();
        it.op = $urandom_range(1) ? OP_NEAREST : ($urandom_range(4) == 0 ? OP_CUT : OP_ANGLE);
        if ($urandom_range(3) != 0) it.qidx = 8'($urandom_range(cnt_now + 1));
        send(it, 0); n++;
      end
      if (n % 500 < 8) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
